// ----- src/bdca_pkg.sv -----
// ----------------------------------------------------------------------------
// bdca_pkg
// types, codes and tables shared by the birth date check and age block
// ----------------------------------------------------------------------------
package bdca_pkg;

	localparam int DAY_W    = 6;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int TDAY_W   = 5;
	localparam int AGE_W    = 14;
	localparam int SINCE_W  = 9;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;

	localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1000;
	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
	localparam logic [AGE_W-1:0]  AGE_MAX  = 14'd8999;
	localparam logic [SINCE_W:0]  YEAR_DAYS = 10'd365;

	// odd part of 100 and 400 is 25: inverse of 25 modulo 2^14 and its multiple bound
	localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
	localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

	localparam logic [TDAY_W-1:0]  TODAY_DAY_RST   = 5'd1;
	localparam logic [MONTH_W-1:0] TODAY_MONTH_RST = 4'd1;
	localparam logic [YEAR_W-1:0]  TODAY_YEAR_RST  = 14'd2000;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_YEAR      = 3'd1,
		ST_MONTH     = 3'd2,
		ST_DAY       = 3'd3,
		ST_DAY30     = 3'd4,
		ST_FEB_COMMON = 3'd5,
		ST_FEB_LEAP  = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TODAY_DAY   = 2'd0,
		REG_TODAY_MONTH = 2'd1,
		REG_TODAY_YEAR  = 2'd2
	} cfg_reg_t;

	localparam logic [MONTH_W-1:0] M_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] M_APR = 4'd4;
	localparam logic [MONTH_W-1:0] M_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] M_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] M_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] M_DEC = 4'd12;

	// days of the whole months before a month, common year
	function automatic logic [SINCE_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [SINCE_W-1:0] d;
		case (m)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// gregorian leap year: divisible by 25 found by multiplying with the inverse
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [2*YEAR_W-1:0] prod;
		logic                div25;
		prod  = y * (2*YEAR_W)'(INV25);
		div25 = (prod[YEAR_W-1:0] <= DIV25_LIM);
		return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

endpackage

// ----- src/birth_date_check_and_age.sv -----
// ----------------------------------------------------------------------------
// birth_date_check_and_age
// checks a birth date under gregorian rules and gives age and days since
// the last birthday against the current date held in registers
// ----------------------------------------------------------------------------
//  channel   dir   handshake                 payload
//  s_axis    in    s_axis_tvalid/tready      birth_day, birth_month, birth_year
//  m_axis    out   m_axis_tvalid/tready      status, age_years, days_since_birthday
//  cfg       in    cfg_wen                   cfg_index, cfg_data
//
//  two register stages: input register, then result register
//  one beat per cycle sustained while m_axis_tready is high; a beat passes the
//  input register and then the result register before m_axis_tvalid rises
//  a stalled output holds; the input stage still takes a beat while it is empty
//  reset clears the valid flags and loads the current date as 1 jan 2000
// ----------------------------------------------------------------------------
module birth_date_check_and_age (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // birth_day[5:0], birth_month[9:6], birth_year[23:10]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // status[2:0], age_years[16:3],
	                                    // days_since_birthday[25:17], zero[31:26]
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	logic [bdca_pkg::TDAY_W-1:0]  today_day_q;
	logic [bdca_pkg::MONTH_W-1:0] today_month_q;
	logic [bdca_pkg::YEAR_W-1:0]  today_year_q;

	logic                          valid_s1;
	logic [bdca_pkg::DAY_W-1:0]    bd_s1;
	logic [bdca_pkg::MONTH_W-1:0]  bm_s1;
	logic [bdca_pkg::YEAR_W-1:0]   by_s1;

	logic                          valid_s2;
	bdca_pkg::status_t             status_s2;
	logic [bdca_pkg::AGE_W-1:0]    age_s2;
	logic [bdca_pkg::SINCE_W-1:0]  since_s2;

	logic                          adv_s2;
	logic                          acc_in;

	bdca_pkg::status_t             status_c;
	logic [bdca_pkg::AGE_W-1:0]    age_c;
	logic [bdca_pkg::SINCE_W-1:0]  since_c;
	logic                          leap_b;
	logic                          leap_t;
	logic [bdca_pkg::MONTH_W-1:0]  tm;
	logic [bdca_pkg::TDAY_W-1:0]   td;
	logic                          bday_ahead;
	logic [bdca_pkg::YEAR_W:0]     age_diff;
	logic [bdca_pkg::YEAR_W:0]     age_adj;
	logic [bdca_pkg::SINCE_W-1:0]  bdoy;
	logic [bdca_pkg::SINCE_W-1:0]  tdoy;
	logic [bdca_pkg::SINCE_W:0]    wrap;

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign acc_in        = s_axis_tvalid && s_axis_tready;

	// current date registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			today_day_q   <= bdca_pkg::TODAY_DAY_RST;
			today_month_q <= bdca_pkg::TODAY_MONTH_RST;
			today_year_q  <= bdca_pkg::TODAY_YEAR_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				bdca_pkg::REG_TODAY_DAY:   today_day_q   <= cfg_data[bdca_pkg::TDAY_W-1:0];
				bdca_pkg::REG_TODAY_MONTH: today_month_q <= cfg_data[bdca_pkg::MONTH_W-1:0];
				bdca_pkg::REG_TODAY_YEAR:  today_year_q  <= cfg_data[bdca_pkg::YEAR_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			bd_s1 <= s_axis_tdata[5:0];
			bm_s1 <= s_axis_tdata[9:6];
			by_s1 <= s_axis_tdata[23:10];
		end
	end

	// check, age and day count
	always_comb begin
		leap_b = bdca_pkg::is_leap(by_s1);
		leap_t = bdca_pkg::is_leap(today_year_q);

		if (by_s1 < bdca_pkg::YEAR_MIN || by_s1 > bdca_pkg::YEAR_MAX) begin
			status_c = bdca_pkg::ST_YEAR;
		end else if (bm_s1 < bdca_pkg::M_JAN || bm_s1 > bdca_pkg::M_DEC) begin
			status_c = bdca_pkg::ST_MONTH;
		end else if (bd_s1 < 6'd1 || bd_s1 > 6'd31) begin
			status_c = bdca_pkg::ST_DAY;
		end else if ((bm_s1 == bdca_pkg::M_APR || bm_s1 == bdca_pkg::M_JUN ||
		              bm_s1 == bdca_pkg::M_SEP || bm_s1 == bdca_pkg::M_NOV) &&
		             bd_s1 > 6'd30) begin
			status_c = bdca_pkg::ST_DAY30;
		end else if (bm_s1 == bdca_pkg::M_FEB && leap_b && bd_s1 > 6'd29) begin
			status_c = bdca_pkg::ST_FEB_LEAP;
		end else if (bm_s1 == bdca_pkg::M_FEB && !leap_b && bd_s1 > 6'd28) begin
			status_c = bdca_pkg::ST_FEB_COMMON;
		end else begin
			status_c = bdca_pkg::ST_OK;
		end

		// clamp current month and day
		tm = today_month_q;
		if (tm < bdca_pkg::M_JAN) tm = bdca_pkg::M_JAN;
		if (tm > bdca_pkg::M_DEC) tm = bdca_pkg::M_DEC;
		td = (today_day_q == 5'd0) ? 5'd1 : today_day_q;

		bday_ahead = (tm < bm_s1) || (tm == bm_s1 && {1'b0, td} < bd_s1);
		age_diff   = {1'b0, today_year_q} - {1'b0, by_s1};
		age_adj    = (bday_ahead && age_diff != '0) ? age_diff - 15'd1 : age_diff;
		if (today_year_q < by_s1) begin
			age_c = '0;
		end else if (age_adj > {1'b0, bdca_pkg::AGE_MAX}) begin
			age_c = bdca_pkg::AGE_MAX;
		end else begin
			age_c = age_adj[bdca_pkg::AGE_W-1:0];
		end

		bdoy = bdca_pkg::days_before(bm_s1) + 9'(bd_s1)
		       + 9'(bm_s1 > bdca_pkg::M_FEB && leap_b);
		tdoy = bdca_pkg::days_before(tm) + 9'(td)
		       + 9'(tm > bdca_pkg::M_FEB && leap_t);
		wrap = {1'b0, tdoy} + bdca_pkg::YEAR_DAYS - {1'b0, bdoy};
		if (tdoy > bdoy) begin
			since_c = tdoy - bdoy;
		end else if (tdoy < bdoy) begin
			since_c = wrap[bdca_pkg::SINCE_W-1:0];
		end else begin
			since_c = '0;
		end

		if (status_c != bdca_pkg::ST_OK) begin
			age_c   = '0;
			since_c = '0;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			status_s2 <= status_c;
			age_s2    <= age_c;
			since_s2  <= since_c;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, since_s2, age_s2, status_s2};

	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> valid_s1)
		else $error("accepted beat missing from input stage");

	a_drain_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("input stage did not move to empty result stage");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && status_s2 != bdca_pkg::ST_OK) |-> (age_s2 == '0 && since_s2 == '0))
		else $error("invalid date with nonzero age or day count");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (age_s2 <= bdca_pkg::AGE_MAX && since_s2 <= 9'd365))
		else $error("age or day count out of range");

endmodule
